[hdl/tdts_pkg.sv]
package tdts_pkg;

    // Fixed field widths.
    localparam int CNT_W  = 4;
    localparam int PRIO_W = 4;
    localparam int TIDX_W = 3;
    localparam int SEED_W = 16;

    // Configuration register indexes.
    localparam int                CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b1;

    // Default sizes.
    localparam int DEF_NUM_TASKS = 8;
    localparam int DEF_KEY_LIMIT = 11;

    // Reset values and generator constants.
    localparam logic [PRIO_W-1:0] PRIO_RESET   = 4'd10;
    localparam logic [SEED_W-1:0] LFSR_DEFAULT = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_MASK    = 16'hB400;

    // Commands broadcast to the task cells.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_DEC   = 2'd2;
    localparam logic [1:0] OP_SHIFT = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cnt;
        logic              policy;
    } t_cmd;

    // One step of the Galois generator.
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

    // Counter refill value: (v mod 10) + 1. The remainder mod 5 comes from the
    // nibble sum (16 is 1 mod 5), and the low bit of v picks between m and m+5.
    function automatic logic [CNT_W-1:0] refill_count(input logic [SEED_W-1:0] v);
        logic [5:0] s;
        logic [4:0] t;
        logic [2:0] m5;
        logic [3:0] r;
        s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        t = 5'(s[5:4]) + 5'(s[3:0]);
        if (t >= 5'd15) begin
            m5 = 3'(t - 5'd15);
        end else if (t >= 5'd10) begin
            m5 = 3'(t - 5'd10);
        end else if (t >= 5'd5) begin
            m5 = 3'(t - 5'd5);
        end else begin
            m5 = 3'(t);
        end
        r = (m5[0] != v[0]) ? (4'(m5) + 4'd5) : 4'(m5);
        return r + 4'd1;
    endfunction

endpackage

[hdl/tdts_cell.sv]
module tdts_cell
    import tdts_pkg::*;
#(
    parameter int CELL_ID = 1,
    parameter int IDX_W   = 3,
    parameter int KEY_W   = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [IDX_W-1:0] i_run_idx,
    input  logic [CNT_W-1:0] i_shift_cnt,
    output logic [CNT_W-1:0] o_cnt,
    output logic [CNT_W-1:0] o_run_cnt,
    input  logic             i_scan_vld,
    input  logic [KEY_W-1:0] i_scan_key,
    input  logic [IDX_W-1:0] i_scan_idx,
    output logic             o_scan_vld,
    output logic [KEY_W-1:0] o_scan_key,
    output logic [IDX_W-1:0] o_scan_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic [CNT_W-1:0]  r_cnt;
    logic [PRIO_W-1:0] r_prio;
    logic              r_scan_vld;
    logic [KEY_W-1:0]  r_scan_key;
    logic [IDX_W-1:0]  r_scan_idx;
    logic [KEY_W-1:0]  key;
    logic              take;
    logic              hit;

    assign hit = (i_idx == MY_IDX);

    // Slot state: load, saturating decrement, or shift along the refill chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_prio <= PRIO_RESET;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (hit) begin
                        r_cnt  <= i_cmd.cnt;
                        r_prio <= i_cmd.prio;
                    end
                end
                OP_DEC: begin
                    if (hit && r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                OP_SHIFT: begin
                    r_cnt <= i_shift_cnt;
                end
                default: begin
                end
            endcase
        end
    end

    // The scan token carries the best key so far; this slot replaces it when
    // it is eligible and strictly better, which keeps the lowest index on ties.
    assign key  = i_cmd.policy ? KEY_W'(r_prio) : KEY_W'(r_cnt);
    assign take = (r_cnt != '0) && (key < i_scan_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
        end else begin
            r_scan_vld <= i_scan_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_scan_key <= key;
            r_scan_idx <= MY_IDX;
        end else begin
            r_scan_key <= i_scan_key;
            r_scan_idx <= i_scan_idx;
        end
    end

    assign o_cnt      = r_cnt;
    assign o_run_cnt  = (i_run_idx == MY_IDX) ? r_cnt : '0;
    assign o_scan_vld = r_scan_vld;
    assign o_scan_key = r_scan_key;
    assign o_scan_idx = r_scan_idx;

endmodule

[hdl/tdts_ctrl.sv]
module tdts_ctrl
    import tdts_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int IDX_W     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEED_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [TIDX_W-1:0]    i_task_index,
    input  logic [PRIO_W-1:0]    i_priority_value,
    input  logic [CNT_W-1:0]     i_counter_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TIDX_W-1:0]    o_running_task,
    output logic                 o_switched,
    output logic                 o_refilled,
    output logic [CNT_W-1:0]     o_running_counter,
    output t_cmd                 o_cmd,
    output logic [IDX_W-1:0]     o_cmd_idx,
    output logic [IDX_W-1:0]     o_run_idx,
    output logic [CNT_W-1:0]     o_inject,
    output logic                 o_scan_go,
    input  logic                 i_tail_vld,
    input  logic [IDX_W-1:0]     i_tail_idx,
    input  logic [CNT_W-1:0]     i_run_cnt
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_REFILL = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [IDX_W-1:0] LAST_SHIFT = IDX_W'(NUM_TASKS - 2);

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_run, n_run;
    logic [IDX_W-1:0]  r_old, n_old;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_refilled, n_refilled;
    logic              r_scan_go, n_scan_go;
    logic              r_policy;
    logic [SEED_W-1:0] r_lfsr;
    logic [SEED_W-1:0] lfsr_next;
    logic              r_out_vld, n_out_vld;
    logic [TIDX_W-1:0] r_out_task;
    logic              r_out_sw;
    logic              r_out_rf;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              accept;
    logic              load_ok;
    logic              out_load;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign load_ok   = (i_task_index != '0) && (int'(i_task_index) < NUM_TASKS);
    assign lfsr_next = lfsr_step(r_lfsr);
    assign out_load  = (r_state == S_FINISH) && (!r_out_vld || !i_out_stall);

    // Sequencer: accept, then either a load, or a decrement check with optional scan and refill.
    always_comb begin
        n_state    = r_state;
        n_run      = r_run;
        n_old      = r_old;
        n_cnt      = r_cnt;
        n_refilled = r_refilled;
        n_scan_go  = 1'b0;
        o_cmd      = '{op: OP_NONE, prio: i_priority_value, cnt: i_counter_value,
                       policy: r_policy};
        o_cmd_idx  = r_run;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_old      = r_run;
                    n_refilled = 1'b0;
                    if (i_mode) begin
                        o_cmd_idx = IDX_W'(i_task_index);
                        if (load_ok) begin
                            o_cmd.op = OP_LOAD;
                        end
                        n_state = S_FINISH;
                    end else begin
                        if (r_run != '0) begin
                            o_cmd.op = OP_DEC;
                        end
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_run != '0 && i_run_cnt != '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_scan_go = 1'b1;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_tail_vld) begin
                    if (i_tail_idx != '0) begin
                        n_run   = i_tail_idx;
                        n_state = S_FINISH;
                    end else if (!r_refilled) begin
                        n_cnt   = '0;
                        n_state = S_REFILL;
                    end else begin
                        n_run   = '0;
                        n_state = S_FINISH;
                    end
                end
            end
            S_REFILL: begin
                o_cmd.op = OP_SHIFT;
                if (r_cnt == LAST_SHIFT) begin
                    n_refilled = 1'b1;
                    n_scan_go  = 1'b1;
                    n_state    = S_SCAN;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_run      <= '0;
            r_old      <= '0;
            r_cnt      <= '0;
            r_refilled <= 1'b0;
            r_scan_go  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_run      <= n_run;
            r_old      <= n_old;
            r_cnt      <= n_cnt;
            r_refilled <= n_refilled;
            r_scan_go  <= n_scan_go;
        end
    end

    // Configuration writes and generator stepping during a refill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
            r_lfsr   <= LFSR_DEFAULT;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_POLICY) begin
                r_policy <= i_cfg_data[0];
            end else begin
                r_lfsr <= (i_cfg_data == '0) ? LFSR_DEFAULT : i_cfg_data;
            end
        end else if (r_state == S_REFILL) begin
            r_lfsr <= lfsr_next;
        end
    end

    // Output register parts the result side from the sequencer.
    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (out_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_task <= TIDX_W'(r_run);
            r_out_sw   <= (r_run != r_old);
            r_out_rf   <= r_refilled;
            r_out_cnt  <= i_run_cnt;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_vld;
    assign o_running_task    = r_out_task;
    assign o_switched        = r_out_sw;
    assign o_refilled        = r_out_rf;
    assign o_running_counter = r_out_cnt;
    assign o_run_idx         = r_run;
    assign o_inject          = refill_count(lfsr_next);
    assign o_scan_go         = r_scan_go;

endmodule

[hdl/tick_driven_task_scheduler.sv]
// A load item passes from acceptance through the finish state to the result; a tick
// that keeps the running task passes through the check state, a tick with a new pick
// also through the scan, and a tick that refills through scan, refill and a second scan.
// One item is in work at a time; the scan token crosses the row of task cells one cell
// per cycle, and the refill shift moves the counters one slot per cycle.
// Reset is synchronous: counters zero, priorities ten, idle task running, seed default.
module tick_driven_task_scheduler
    import tdts_pkg::*;
#(
    parameter int NUM_TASKS = DEF_NUM_TASKS,
    parameter int KEY_LIMIT = DEF_KEY_LIMIT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SEED_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [TIDX_W-1:0]    i_task_index,
    input  logic [PRIO_W-1:0]    i_priority_value,
    input  logic [CNT_W-1:0]     i_counter_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [TIDX_W-1:0]    o_running_task,
    output logic                 o_switched,
    output logic                 o_refilled,
    output logic [CNT_W-1:0]     o_running_counter
);

    localparam int IDX_W  = $clog2(NUM_TASKS);
    localparam int KL_W   = $clog2(KEY_LIMIT + 1);
    localparam int KEY_W  = (KL_W > CNT_W) ? KL_W : CNT_W;
    localparam int LAST   = NUM_TASKS - 1;

    t_cmd             cmd;
    logic [IDX_W-1:0] cmd_idx;
    logic [IDX_W-1:0] run_idx;
    logic [CNT_W-1:0] inject;
    logic             scan_go;
    logic [CNT_W-1:0] run_cnt;

    logic [CNT_W-1:0] cell_cnt   [LAST:1];
    logic [CNT_W-1:0] cell_shift [LAST:1];
    logic [CNT_W-1:0] cell_rcnt  [LAST:1];
    logic             scan_vld_i [LAST:1];
    logic [KEY_W-1:0] scan_key_i [LAST:1];
    logic [IDX_W-1:0] scan_idx_i [LAST:1];
    logic [LAST:1]    scan_vld_o;
    logic [KEY_W-1:0] scan_key_o [LAST:1];
    logic [IDX_W-1:0] scan_idx_o [LAST:1];

    tdts_ctrl #(
        .NUM_TASKS (NUM_TASKS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_task_index      (i_task_index),
        .i_priority_value  (i_priority_value),
        .i_counter_value   (i_counter_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_running_task    (o_running_task),
        .o_switched        (o_switched),
        .o_refilled        (o_refilled),
        .o_running_counter (o_running_counter),
        .o_cmd             (cmd),
        .o_cmd_idx         (cmd_idx),
        .o_run_idx         (run_idx),
        .o_inject          (inject),
        .o_scan_go         (scan_go),
        .i_tail_vld        (scan_vld_o[LAST]),
        .i_tail_idx        (scan_idx_o[LAST]),
        .i_run_cnt         (run_cnt)
    );

    // Row of task cells: the scan runs toward the last slot, refill values
    // enter at the last slot and shift toward slot 1.
    for (genvar k = 1; k <= LAST; k++) begin : g_cell
        if (k == LAST) begin : g_tail
            assign cell_shift[k] = inject;
        end else begin : g_mid
            assign cell_shift[k] = cell_cnt[k+1];
        end
        if (k == 1) begin : g_head
            assign scan_vld_i[k] = scan_go;
            assign scan_key_i[k] = KEY_W'(KEY_LIMIT);
            assign scan_idx_i[k] = '0;
        end else begin : g_link
            assign scan_vld_i[k] = scan_vld_o[k-1];
            assign scan_key_i[k] = scan_key_o[k-1];
            assign scan_idx_i[k] = scan_idx_o[k-1];
        end

        tdts_cell #(
            .CELL_ID (k),
            .IDX_W   (IDX_W),
            .KEY_W   (KEY_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_idx       (cmd_idx),
            .i_run_idx   (run_idx),
            .i_shift_cnt (cell_shift[k]),
            .o_cnt       (cell_cnt[k]),
            .o_run_cnt   (cell_rcnt[k]),
            .i_scan_vld  (scan_vld_i[k]),
            .i_scan_key  (scan_key_i[k]),
            .i_scan_idx  (scan_idx_i[k]),
            .o_scan_vld  (scan_vld_o[k]),
            .o_scan_key  (scan_key_o[k]),
            .o_scan_idx  (scan_idx_o[k])
        );
    end

    // Only the running cell drives a nonzero counter; the idle task reads zero.
    always_comb begin
        run_cnt = '0;
        for (int k = 1; k <= LAST; k++) begin
            run_cnt = run_cnt | cell_rcnt[k];
        end
    end

`ifndef NO_ASSERTIONS
    // At most one scan token travels the row.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(scan_vld_o))
        else $error("more than one scan token in the cell row");

    // A token at the last cell was launched earlier by a scan start and has crossed the whole row.
    a_token_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_vld_o[LAST] |-> $past(scan_go, LAST))
        else $error("scan token arrived without a matching launch");

    // An accepted item keeps the input side busy on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input side free right after an accepted item");
`endif

endmodule
